FILE: src/moe_token_route_planner_unit_macros.svh
// assertion macros for the route planner checker
// no dependencies
`ifndef MOE_TOKEN_ROUTE_PLANNER_UNIT_MACROS_SVH
`define MOE_TOKEN_ROUTE_PLANNER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define MTRP_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define MTRP_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: src/mtrp_pkg.sv
// types and constants for the route planner
// no dependencies
package mtrp_pkg;
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [31:0] ONE_F32 = 32'h3F800000;
	localparam int CFG_TOKEN_COUNT = 0;
	localparam int CFG_TOPK = 1;
	localparam int CFG_WORLD_SIZE = 2;
	localparam int CFG_WORKER_RANK = 3;
	localparam int CFG_EPW = 4;
	localparam int CFG_GENERATION = 5;
	localparam int CFG_FLAGS = 6;
	localparam int CFG_SEED = 7;

	typedef struct packed {
		logic [31:0] expert_id;
		logic        has_destination;
		logic [31:0] given_destination;
		logic        has_weight;
		logic [31:0] wgt_raw;
	} in_t;

	typedef struct packed {
		logic        invalid;
		logic [15:0] destination;
		logic [31:0] weight_out;
		logic        done_res;
		logic [63:0] plan_digest;
		logic [35:0] global_rows;
		logic [35:0] local_assignment_count;
		logic [35:0] local_rows;
	} out_t;

	// per-slot match flags handed along the cell chain
	typedef struct packed {
		logic exp_hit;
		logic dst_hit;
	} match_t;

	function automatic logic [63:0] mix(input logic [63:0] d, input logic [63:0] v);
		return d ^ (v + GOLDEN + (d << 6) + (d >> 2));
	endfunction
endpackage

FILE: src/mtrp_if.sv
// valid/ready channel carrying one payload
// depends on nothing
interface mtrp_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/mtrp_cell.sv
// one slot cell: holds expert and destination, compares a key passing by
// depends on mtrp_pkg
module mtrp_cell (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 active,
	input  logic [31:0]          key_exp,
	input  logic [15:0]          key_dst,
	input  logic [31:0]          wr_exp,
	input  logic [15:0]          wr_dst,
	input  mtrp_pkg::match_t     m_in,
	output mtrp_pkg::match_t     m_out
);
	logic [31:0] exp_q;
	logic [15:0] dst_q;
	always_ff @(posedge clk) begin
		if (load) begin
			exp_q <= wr_exp;
			dst_q <= wr_dst;
		end
	end
	always_comb begin
		m_out.exp_hit = m_in.exp_hit | (active & (exp_q == key_exp));
		m_out.dst_hit = m_in.dst_hit | (active & (dst_q == key_dst));
	end
endmodule

FILE: src/mtrp_divider.sv
// restoring divider, one quotient bit per cycle
// depends on nothing
module mtrp_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	assign trial = {rem_q, quo_q[31]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (start) cnt_q <= 6'd32;
		else if (cnt_q != 0) cnt_q <= cnt_q - 6'd1;
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 0) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 32'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
	assign busy = (cnt_q != 0);
	assign quotient = quo_q;
endmodule

FILE: src/moe_token_route_planner_unit.sv
// top level of the mixture-of-experts route planner
// depends on mtrp_pkg, mtrp_if, mtrp_cell, mtrp_divider
// sequence: a transaction is accepted in idle, passes the divider if its destination
// is computed, then the header step (six header mixes on a plan's first transaction),
// the checks, the item mixes (skipped once the plan is in error) and the result write
// one transaction at a time: the next is taken after the result is written; a result
// held by the sink stalls only the final step
// reset: arst_n clears control, counters, registers and the slot index at once
module moe_token_route_planner_unit #(
	parameter int SLOT_CAP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	mtrp_if.sink        in_ch,
	mtrp_if.source      out_ch
);
	localparam int SW = $clog2(SLOT_CAP + 1);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_HDR = 3'd2,
		ST_CHK = 3'd3, ST_MIX = 3'd4, ST_OUT = 3'd5;

	// configuration registers
	logic [31:0] token_count_q, epw_q, flags_q;
	logic [4:0]  topk_q;
	logic [15:0] world_q, rank_q;
	logic [63:0] gen_q, seed_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_count_q <= '0; topk_q <= '0; world_q <= '0; rank_q <= '0;
			epw_q <= '0; gen_q <= '0; flags_q <= '0; seed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				3'(mtrp_pkg::CFG_TOKEN_COUNT): token_count_q <= cfg_data[31:0];
				3'(mtrp_pkg::CFG_TOPK): topk_q <= cfg_data[4:0];
				3'(mtrp_pkg::CFG_WORLD_SIZE): world_q <= cfg_data[15:0];
				3'(mtrp_pkg::CFG_WORKER_RANK): rank_q <= cfg_data[15:0];
				3'(mtrp_pkg::CFG_EPW): epw_q <= cfg_data[31:0];
				3'(mtrp_pkg::CFG_GENERATION): gen_q <= cfg_data;
				3'(mtrp_pkg::CFG_FLAGS): flags_q <= cfg_data[31:0];
				default: seed_q <= cfg_data;
			endcase
		end
	end

	logic [2:0]  state_q;
	logic [2:0]  step_q;       // mix step counter
	mtrp_pkg::in_t it_q;
	logic [63:0] digest_q;
	logic [31:0] tok_q;
	logic [SW-1:0] slot_q;
	logic [35:0] grows_q, lassign_q, lrows_q;
	logic        err_q, bad_q, seen_q, first_q;
	logic [31:0] dest_q;
	logic [31:0] wbits_q;
	mtrp_pkg::out_t res_q;
	logic        res_v_q;

	// effective topk and plan end
	logic [SW-1:0] topk_eff;
	assign topk_eff = (32'(topk_q) > SLOT_CAP) ? SW'(SLOT_CAP) : SW'(topk_q);
	logic last;
	assign last = ({1'b0, tok_q} + 33'd1 >= {1'b0, token_count_q}) &&
		({1'b0, slot_q} + (SW+1)'(1) >= {1'b0, topk_eff});

	// divider, started as a transaction without a given destination is accepted
	logic div_busy, div_start;
	logic [31:0] quotient;
	mtrp_divider u_div (.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(in_ch.data.expert_id), .divisor(epw_q), .busy(div_busy),
		.quotient(quotient));

	// cell chain over earlier slots of this token
	mtrp_pkg::match_t chain [SLOT_CAP+1];
	assign chain[0] = '0;
	for (genvar g = 0; g < SLOT_CAP; g++) begin : g_cell
		mtrp_cell u_cell (.clk(clk),
			.load(state_q == ST_OUT && slot_q == SW'(g)),
			.active(SW'(g) < slot_q), .key_exp(it_q.expert_id),
			.key_dst(dest_q[15:0]), .wr_exp(it_q.expert_id), .wr_dst(dest_q[15:0]),
			.m_in(chain[g]), .m_out(chain[g+1]));
	end

	logic [63:0] cap;
	assign cap = 64'(world_q) * 64'(epw_q);

	// header and item mix operand
	logic [63:0] mix_v;
	always_comb begin
		mix_v = '0;
		if (state_q == ST_HDR) begin
			unique case (step_q)
				3'd0: mix_v = 64'(token_count_q);
				3'd1: mix_v = 64'(topk_q);
				3'd2: mix_v = 64'(world_q);
				3'd3: mix_v = 64'(epw_q);
				3'd4: mix_v = gen_q;
				default: mix_v = 64'(flags_q);
			endcase
		end else begin
			unique case (step_q)
				3'd0: mix_v = 64'(tok_q);
				3'd1: mix_v = 64'(slot_q);
				3'd2: mix_v = 64'(it_q.expert_id);
				3'd3: mix_v = 64'(dest_q);
				default: mix_v = 64'(wbits_q);
			endcase
		end
	end

	// result register parts the two sides: a new transaction may start while one waits
	logic out_free;
	assign out_free = !res_v_q || out_ch.ready;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_IDLE) && in_ch.valid && in_ch.ready &&
		!in_ch.data.has_destination;
	assign out_ch.valid = res_v_q;
	assign out_ch.data = res_q;

	logic cfg_bad;
	assign cfg_bad = token_count_q == 0 || topk_q == 0 || 32'(topk_q) > SLOT_CAP ||
		world_q == 0 || rank_q >= world_q;
	logic ok;
	assign ok = !err_q && !bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; step_q <= '0; tok_q <= '0; slot_q <= '0;
			digest_q <= '0; grows_q <= '0; lassign_q <= '0; lrows_q <= '0;
			err_q <= 1'b0; res_v_q <= 1'b0; bad_q <= 1'b0; seen_q <= 1'b0;
			first_q <= 1'b0; it_q <= '0; wbits_q <= '0; dest_q <= '0; res_q <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) res_v_q <= 1'b1;
			else if (out_ch.ready) res_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						it_q <= in_ch.data;
						wbits_q <= in_ch.data.has_weight ? in_ch.data.wgt_raw :
							mtrp_pkg::ONE_F32;
						dest_q <= in_ch.data.given_destination;
						first_q <= (tok_q == 0) && (slot_q == 0);
						step_q <= '0;
						state_q <= in_ch.data.has_destination ? ST_HDR : ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy && !div_start) begin
						dest_q <= ({32'd0, it_q.expert_id} >= cap || epw_q == 0) ?
							32'd0 : quotient;
						state_q <= ST_HDR;
					end
				end
				ST_HDR: begin
					// plan start: seed, header mixes, clear counters and error; otherwise on to the checks
					if (!first_q) begin
						state_q <= ST_CHK;
					end else begin
						digest_q <= mtrp_pkg::mix(step_q == 3'd0 ? seed_q : digest_q, mix_v);
						if (step_q == 3'd0) begin
							grows_q <= '0; lassign_q <= '0; lrows_q <= '0; err_q <= 1'b0;
						end
						if (step_q == 3'd5) begin
							step_q <= '0; state_q <= ST_CHK;
						end else step_q <= step_q + 3'd1;
					end
				end
				ST_CHK: begin
					bad_q <= cfg_bad || it_q.expert_id[31] ||
						(!it_q.has_destination &&
						 ({32'd0, it_q.expert_id} >= cap || epw_q == 0)) ||
						(dest_q >= 32'(world_q)) || (wbits_q[30:23] == 8'hFF) ||
						chain[SLOT_CAP].exp_hit;
					seen_q <= chain[SLOT_CAP].dst_hit;
					step_q <= '0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					if (!ok) begin
						err_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						digest_q <= mtrp_pkg::mix(digest_q, mix_v);
						if (step_q == 3'd4) state_q <= ST_OUT;
						else step_q <= step_q + 3'd1;
					end
				end
				ST_OUT: begin
					logic [35:0] g, la, lr;
					logic loc;
					loc = (dest_q == 32'(rank_q));
					g = grows_q + 36'(!seen_q);
					lr = lrows_q + 36'(!seen_q && loc);
					la = lassign_q + 36'(loc);
					// wait here while the previous result is still held
					if (out_free) begin
						if (!err_q) begin
							grows_q <= g; lrows_q <= lr; lassign_q <= la;
						end
						res_q.invalid <= err_q;
						res_q.destination <= dest_q[15:0];
						res_q.weight_out <= wbits_q;
						res_q.done_res <= last;
						res_q.plan_digest <= (last && !err_q) ?
							((digest_q == 0) ? 64'd1 : digest_q) : 64'd0;
						res_q.global_rows <= (last && !err_q) ? g : '0;
						res_q.local_assignment_count <= (last && !err_q) ? la : '0;
						res_q.local_rows <= (last && !err_q) ? lr : '0;
						bad_q <= 1'b0;
						if (last) begin
							tok_q <= '0; slot_q <= '0;
						end else if ({1'b0, slot_q} + (SW+1)'(1) < {1'b0, topk_eff}) begin
							slot_q <= slot_q + SW'(1);
						end else begin
							slot_q <= '0; tok_q <= tok_q + 32'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: src/mtrp_checker.sv
// port-level checks for the route planner
// depends on moe_token_route_planner_unit_macros.svh, mtrp_pkg
`include "moe_token_route_planner_unit_macros.svh"
module mtrp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input mtrp_pkg::out_t out_data
);
	`MTRP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`MTRP_ASSERT_IMP(a_digest_only_last, clk, arst_n, out_valid && !out_data.done_res, out_data.plan_digest == 64'd0)
	`MTRP_ASSERT_IMP(a_invalid_zero, clk, arst_n, out_valid && out_data.invalid, out_data.global_rows == 36'd0 && out_data.plan_digest == 64'd0)
	`MTRP_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind moe_token_route_planner_unit mtrp_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data));

FILE: dv/moe_token_route_planner_unit_tb.sv
// self-checking testbench for the mixture-of-experts route planner
// depends on mtrp_pkg, mtrp_if and moe_token_route_planner_unit
module moe_token_route_planner_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOPK_MAX = 16;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [35:0] CNT_MASK = 36'hF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	always #1 clk = ~clk;

	mtrp_if #(.T(mtrp_pkg::in_t)) in_ch (clk);
	mtrp_if #(.T(mtrp_pkg::out_t)) out_ch (clk);

	moe_token_route_planner_unit #(.SLOT_CAP(TOPK_MAX)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// shadow of the configuration registers
	logic [31:0] sh_tokens;
	logic [4:0]  sh_topk;
	logic [15:0] sh_world;
	logic [15:0] sh_rank;
	logic [31:0] sh_epw;
	logic [63:0] sh_gen;
	logic [31:0] sh_flags;
	logic [63:0] sh_seed;

	// planner state as the predictor sees it
	logic [63:0] pl_digest;
	logic [31:0] pl_token;
	logic [31:0] pl_slot;
	logic [31:0] pl_experts [TOPK_MAX];
	logic [15:0] pl_dests [TOPK_MAX];
	logic [35:0] pl_global, pl_local_assign, pl_local_rows;
	logic        pl_err;

	mtrp_pkg::out_t route_expect_q [$];
	int fail_count = 0;
	longint cycle_count = 0;
	int wr_phase = 0;

	function automatic logic [63:0] fold(logic [63:0] d, logic [63:0] v);
		return d ^ (v + mtrp_pkg::GOLDEN + (d << 6) + (d >> 2));
	endfunction

	// works out the route of one assignment and advances the planner state
	function automatic mtrp_pkg::out_t plan_route(mtrp_pkg::in_t it);
		mtrp_pkg::out_t r;
		logic [31:0] w;
		logic [63:0] dst, cap;
		logic bad, seen, last;
		int eff;
		w = it.has_weight ? it.wgt_raw : mtrp_pkg::ONE_F32;
		eff = (sh_topk < TOPK_MAX) ? int'(sh_topk) : TOPK_MAX;
		dst = '0;
		bad = 1'b0;
		seen = 1'b0;
		if (pl_token == 0 && pl_slot == 0) begin
			pl_digest = sh_seed;
			pl_digest = fold(pl_digest, {32'd0, sh_tokens});
			pl_digest = fold(pl_digest, {59'd0, sh_topk});
			pl_digest = fold(pl_digest, {48'd0, sh_world});
			pl_digest = fold(pl_digest, {32'd0, sh_epw});
			pl_digest = fold(pl_digest, sh_gen);
			pl_digest = fold(pl_digest, {32'd0, sh_flags});
			pl_global = '0;
			pl_local_assign = '0;
			pl_local_rows = '0;
			pl_err = 1'b0;
		end
		if (sh_tokens == 0 || sh_topk == 0 || sh_topk > TOPK_MAX || sh_world == 0
			|| sh_rank >= sh_world)
			bad = 1'b1;
		if (it.expert_id[31])
			bad = 1'b1;
		if (it.has_destination) begin
			dst = {32'd0, it.given_destination};
		end else begin
			cap = 64'(sh_world) * 64'(sh_epw);
			if (64'(it.expert_id) >= cap || sh_epw == 0)
				bad = 1'b1;
			else
				dst = 64'(it.expert_id) / 64'(sh_epw);
		end
		if (dst >= 64'(sh_world))
			bad = 1'b1;
		if (w[30:23] == 8'hFF)
			bad = 1'b1;
		for (int p = 0; p < pl_slot && p < TOPK_MAX; p++)
			if (pl_experts[p] == it.expert_id)
				bad = 1'b1;
		if (!pl_err && !bad) begin
			for (int p = 0; p < pl_slot && p < TOPK_MAX; p++)
				if (64'(pl_dests[p]) == dst)
					seen = 1'b1;
			if (!seen) begin
				pl_global = (pl_global + 36'd1) & CNT_MASK;
				if (dst == 64'(sh_rank))
					pl_local_rows = (pl_local_rows + 36'd1) & CNT_MASK;
			end
			if (dst == 64'(sh_rank))
				pl_local_assign = (pl_local_assign + 36'd1) & CNT_MASK;
			pl_digest = fold(pl_digest, {32'd0, pl_token});
			pl_digest = fold(pl_digest, {32'd0, pl_slot});
			pl_digest = fold(pl_digest, {32'd0, it.expert_id});
			pl_digest = fold(pl_digest, dst);
			pl_digest = fold(pl_digest, {32'd0, w});
		end else begin
			pl_err = 1'b1;
		end
		if (pl_slot < TOPK_MAX) begin
			pl_experts[pl_slot] = it.expert_id;
			pl_dests[pl_slot] = dst[15:0];
		end
		last = (64'(pl_token) + 1 >= 64'(sh_tokens)) && (64'(pl_slot) + 1 >= 64'(eff));
		r = '0;
		r.invalid = pl_err;
		r.destination = dst[15:0];
		r.weight_out = w;
		r.done_res = last;
		if (last && !pl_err) begin
			r.plan_digest = (pl_digest == 0) ? 64'd1 : pl_digest;
			r.global_rows = pl_global;
			r.local_assignment_count = pl_local_assign;
			r.local_rows = pl_local_rows;
		end
		if (last) begin
			pl_token = '0;
			pl_slot = '0;
		end else if (64'(pl_slot) + 1 < 64'(eff)) begin
			pl_slot++;
		end else begin
			pl_slot = '0;
			pl_token++;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
		fail_count++;
	endtask

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, checked on the rising edge
	always @(posedge clk) begin
		mtrp_pkg::out_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (route_expect_q.size() == 0) begin
				report_mismatch("unexpected transaction", 64'd0, 64'd0);
			end else begin
				want = route_expect_q.pop_front();
				if (out_ch.data.invalid !== want.invalid)
					report_mismatch("invalid", 64'(out_ch.data.invalid), 64'(want.invalid));
				if (out_ch.data.destination !== want.destination)
					report_mismatch("destination", 64'(out_ch.data.destination),
						64'(want.destination));
				if (out_ch.data.weight_out !== want.weight_out)
					report_mismatch("weight_out", 64'(out_ch.data.weight_out),
						64'(want.weight_out));
				if (out_ch.data.done_res !== want.done_res)
					report_mismatch("done_res", 64'(out_ch.data.done_res), 64'(want.done_res));
				if (out_ch.data.plan_digest !== want.plan_digest)
					report_mismatch("plan_digest", out_ch.data.plan_digest, want.plan_digest);
				if (out_ch.data.global_rows !== want.global_rows)
					report_mismatch("global_rows", 64'(out_ch.data.global_rows),
						64'(want.global_rows));
				if (out_ch.data.local_assignment_count !== want.local_assignment_count)
					report_mismatch("local_assignment_count",
						64'(out_ch.data.local_assignment_count),
						64'(want.local_assignment_count));
				if (out_ch.data.local_rows !== want.local_rows)
					report_mismatch("local_rows", 64'(out_ch.data.local_rows),
						64'(want.local_rows));
			end
		end
	end

	// ready toggles on the falling edge: mostly short stalls, a few long ones
	initial begin
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (wr_phase == 1) begin
				out_ch.ready <= 1'b1;
			end else begin
				case ($urandom_range(0, 9))
				0, 1, 2: begin
					out_ch.ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end
				3: begin
					out_ch.ready <= 1'b0;
					hold = $urandom_range(10, 60);
				end
				default: begin
					out_ch.ready <= 1'b1;
					hold = $urandom_range(0, 8);
				end
				endcase
			end
		end
	end

	task automatic write_reg(int idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 3'(idx);
		cfg_data <= val;
		case (idx)
		mtrp_pkg::CFG_TOKEN_COUNT: sh_tokens = val[31:0];
		mtrp_pkg::CFG_TOPK:        sh_topk = val[4:0];
		mtrp_pkg::CFG_WORLD_SIZE:  sh_world = val[15:0];
		mtrp_pkg::CFG_WORKER_RANK: sh_rank = val[15:0];
		mtrp_pkg::CFG_EPW:         sh_epw = val[31:0];
		mtrp_pkg::CFG_GENERATION:  sh_gen = val;
		mtrp_pkg::CFG_FLAGS:       sh_flags = val[31:0];
		mtrp_pkg::CFG_SEED:        sh_seed = val;
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the block to drain before touching registers
	task automatic drain();
		while (route_expect_q.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_plan(logic [31:0] tok, logic [4:0] k, logic [15:0] ws,
		logic [15:0] rk, logic [31:0] epw);
		drain();
		write_reg(mtrp_pkg::CFG_TOKEN_COUNT, 64'(tok));
		write_reg(mtrp_pkg::CFG_TOPK, 64'(k));
		write_reg(mtrp_pkg::CFG_WORLD_SIZE, 64'(ws));
		write_reg(mtrp_pkg::CFG_WORKER_RANK, 64'(rk));
		write_reg(mtrp_pkg::CFG_EPW, 64'(epw));
		write_reg(mtrp_pkg::CFG_GENERATION, {$urandom, $urandom});
		write_reg(mtrp_pkg::CFG_FLAGS, 64'($urandom));
		write_reg(mtrp_pkg::CFG_SEED, {$urandom, $urandom});
	endtask

	// one transaction on the input side, with a random gap in front
	task automatic send_item(mtrp_pkg::in_t it);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
		if ($urandom_range(0, 3) == 0)
			gap = 1;
		repeat (gap) @(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		route_expect_q.push_back(plan_route(it));
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// input handshake for a row whose expectation is already queued
	task automatic send_item_noqueue(mtrp_pkg::in_t it);
		repeat ($urandom_range(1, 3)) @(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// random assignment; mostly well formed against the current plan
	function automatic mtrp_pkg::in_t rand_item();
		mtrp_pkg::in_t it;
		logic [31:0] span;
		it.expert_id = $urandom;
		it.has_destination = 1'($urandom_range(0, 1));
		it.given_destination = $urandom;
		it.has_weight = 1'($urandom_range(0, 1));
		it.wgt_raw = $urandom;
		if ($urandom_range(0, 9) != 0) begin
			span = (sh_epw == 0 || sh_world == 0) ? 32'd64
				: 32'((64'(sh_world) * 64'(sh_epw) > 64'h7fff_ffff) ? 64'h7fff_ffff
				: 64'(sh_world) * 64'(sh_epw));
			it.expert_id = (pl_slot < TOPK_MAX && $urandom_range(0, 19) == 0 && pl_slot > 0)
				? pl_experts[$urandom_range(0, pl_slot - 1)]
				: 32'($urandom_range(0, span - 1));
			it.given_destination = (sh_world == 0) ? 32'd0
				: 32'($urandom_range(0, 32'(sh_world) - 1));
			if ($urandom_range(0, 2) == 0)
				it.given_destination = 32'(sh_rank);
			it.wgt_raw[30:23] = 8'($urandom_range(0, 254));
		end
		return it;
	endfunction

	typedef struct {
		mtrp_pkg::in_t it;
		logic chk;
		logic inv;
		logic done;
	} vec_t;

	initial begin
		vec_t dir_tab [$];
		mtrp_pkg::out_t got;
		int n;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		{sh_tokens, sh_topk, sh_world, sh_rank, sh_epw, sh_gen, sh_flags, sh_seed} = '0;
		pl_digest = '0;
		pl_token = '0;
		pl_slot = '0;
		pl_global = '0;
		pl_local_assign = '0;
		pl_local_rows = '0;
		pl_err = 1'b0;
		for (int i = 0; i < TOPK_MAX; i++) begin
			pl_experts[i] = '0;
			pl_dests[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// after reset every register is zero: each item is an invalid last item
		dir_tab.push_back('{'{32'd0, 1'b1, 32'd0, 1'b0, 32'd0}, 1'b1, 1'b1, 1'b1});
		dir_tab.push_back('{'{32'h8000_0000, 1'b0, 32'd0, 1'b1, 32'hFFFF_FFFF},
			1'b1, 1'b1, 1'b1});
		foreach (dir_tab[i]) begin
			got = plan_route(dir_tab[i].it);
			if (dir_tab[i].chk && (got.invalid !== dir_tab[i].inv
				|| got.done_res !== dir_tab[i].done))
				report_mismatch("predictor table row", 64'(i), 64'd0);
			route_expect_q.push_back(got);
			send_item_noqueue(dir_tab[i].it);
		end

		// directed plan: 2 tokens, topk 4, extremes and a repeated expert
		set_plan(32'd2, 5'd4, 16'd4, 16'd1, 32'd8);
		dir_tab.delete();
		dir_tab.push_back('{'{32'd0, 1'b0, 32'd0, 1'b0, 32'd0}, 1'b0, 1'b0, 1'b0});
		dir_tab.push_back('{'{32'd31, 1'b0, 32'd0, 1'b1, 32'h7F7F_FFFF}, 1'b0, 1'b0, 1'b0});
		dir_tab.push_back('{'{32'd9, 1'b1, 32'd1, 1'b1, 32'h0000_0000}, 1'b0, 1'b0, 1'b0});
		dir_tab.push_back('{'{32'd10, 1'b1, 32'd1, 1'b1, 32'h8000_0001}, 1'b0, 1'b0, 1'b0});
		// second token: repeated expert, then sticky error to the end
		dir_tab.push_back('{'{32'd5, 1'b0, 32'd0, 1'b0, 32'd0}, 1'b0, 1'b0, 1'b0});
		dir_tab.push_back('{'{32'd5, 1'b0, 32'd0, 1'b0, 32'd0}, 1'b1, 1'b1, 1'b0});
		dir_tab.push_back('{'{32'd6, 1'b0, 32'd0, 1'b0, 32'd0}, 1'b1, 1'b1, 1'b0});
		dir_tab.push_back('{'{32'd7, 1'b0, 32'd0, 1'b0, 32'd0}, 1'b1, 1'b1, 1'b1});
		// next plan, same shape: bad destination, then infinite weights for the rest of its first token
		dir_tab.push_back('{'{32'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'd0}, 1'b1, 1'b1, 1'b0});
		foreach (dir_tab[i]) begin
			got = plan_route(dir_tab[i].it);
			if (dir_tab[i].chk && (got.invalid !== dir_tab[i].inv
				|| got.done_res !== dir_tab[i].done))
				report_mismatch("predictor table row", 64'(i), 64'd0);
			route_expect_q.push_back(got);
			send_item_noqueue(dir_tab[i].it);
		end
		for (int s = 1; s < 4; s++)
			send_item('{32'(s + 1), 1'b0, 32'd0, 1'b1, 32'hFF80_0000});

		// topk above the slot limit, then maximal counts
		set_plan(32'd1, 5'd31, 16'd2, 16'd0, 32'd1);
		for (int s = 0; s < TOPK_MAX; s++)
			send_item('{32'(s), 1'b0, 32'd0, 1'b0, 32'd0});
		set_plan(32'd1, 5'd16, 16'hFFFF, 16'hFFFE, 32'hFFFF_FFFF);
		for (int s = 0; s < TOPK_MAX; s++)
			send_item('{32'h7FFF_FFF0 + 32'(s), 1'b0, 32'd0, 1'b1, 32'h3F00_0000});
		set_plan(32'hFFFF_FFFF, 5'd1, 16'd1, 16'd1, 32'd0);
		send_item('{32'd3, 1'b0, 32'd0, 1'b0, 32'd0});

		// random plans, small sizes mostly
		n = 0;
		while (n < 1750) begin
			set_plan(($urandom_range(0, 30) == 0) ? 32'd0 : 32'($urandom_range(1, 6)),
				($urandom_range(0, 30) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)),
				($urandom_range(0, 30) == 0) ? 16'hFFFF : 16'($urandom_range(1, 8)),
				16'($urandom_range(0, 7)),
				($urandom_range(0, 20) == 0) ? $urandom : 32'($urandom_range(1, 20)));
			if (sh_rank >= sh_world && $urandom_range(0, 3) != 0)
				write_reg(mtrp_pkg::CFG_WORKER_RANK, 64'(sh_world - 16'd1));
			do begin
				send_item(rand_item());
				n++;
			end while (!(pl_token == 0 && pl_slot == 0) && n < 4000);
		end

		wr_phase = 1;
		drain();
		if (fail_count == 0 && route_expect_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
